[rtl/sfd_pkg.sv]
// Shared types and constants of the scale frame deframer.
package sfd_pkg;

    localparam logic [7:0] SYNC_BYTE_0  = 8'hEF;
    localparam logic [7:0] SYNC_BYTE_1  = 8'hDD;
    localparam logic [7:0] TYPE_WEIGHT  = 8'h0C;
    localparam logic [7:0] TYPE_BATTERY = 8'h08;
    localparam logic [7:0] TYPE_INFO    = 8'h07;
    localparam logic [7:0] EVT_WEIGHT   = 8'h05;
    localparam logic [7:0] EVT_BEAT     = 8'h0B;
    localparam logic [7:0] BEAT_SEL     = 8'h05;
    localparam logic [6:0] BATT_MASK    = 7'h7F;
    localparam logic [6:0] BATT_FULL    = 7'd100;
    localparam logic [7:0] MAX_LEN_RST  = 8'd64;

    // frame positions
    localparam logic [8:0] POS_HDR      = 9'd2;
    localparam logic [8:0] POS_HDR_LAST = 9'd4;
    localparam logic [8:0] POS_BODY     = 9'd5;
    localparam logic [8:0] POS_BODY_END = 9'd13;
    localparam logic [8:0] POS_CHECK    = 9'd6;
    localparam logic [8:0] END_WEIGHT   = 9'd11;
    localparam logic [8:0] END_BEAT     = 9'd14;

    typedef enum logic [2:0] {
        KIND_WEIGHT    = 3'd0,
        KIND_BATTERY   = 3'd1,
        KIND_BATT_OOR  = 3'd2,
        KIND_RESYNC    = 3'd3,
        KIND_OTHER     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SAW_EF = 2'd1,
        PH_FRAME  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_REPLAY = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic       feed_en;     // advance the deframer by one byte
        logic       sel_replay;  // byte comes from the replay buffer
        logic [1:0] rep_idx;
        logic       sess_clear;
        logic       load_out;    // capture the result into the output register
        logic       capture_rep; // hold the bytes to scan again
    } dp_cmd_t;

    typedef struct packed {
        logic ev_valid;   // the byte being fed finishes a request
        logic rep_req;    // held bytes must be scanned again
        logic rep_short;  // only the last held byte is scanned again
    } dp_status_t;

endpackage

[rtl/scale_frame_deframer.sv]
// Top level of the scale frame deframer: byte stream in, frame events out.
//
//  channel  | direction | handshake           | contents
//  ---------+-----------+---------------------+---------------------------------------
//  s_*      | in        | s_tvalid / s_tready | one received byte or a session reset
//  m_*      | out       | m_tvalid / m_tready | one frame event (request)
//  cfg_*    | in        | cfg_valid/cfg_ready | max_payload_len write, always ready
//
//  One byte is taken per cycle when not stalled. A byte that forces a resync
//  stalls the input while the replay sequencer scans the four held bytes again
//  through the header hunt; a frame with length zero stalls it while the last
//  held byte is scanned again. The output register holds one request, and a
//  request held by m_tready low also stalls the input. Reset clears the hunt, the
//  flags, the info count and the output valid, and sets max_payload_len to 64.
module scale_frame_deframer
    import sfd_pkg::*;
#(
    parameter int INFO_COUNT_BITS = 16,
    localparam int TDATA_W        = ((50 + 16 + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    input  logic [0:0]         s_tuser,   // [0] action
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] message_type, [31:8] weight_magnitude, [39:32] decimal_places,
    // [40] weight_negative, [41] first_weight, [48:42] battery_level,
    // [49] scale_responded, [65:50] info_frame_count, zero fill above
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser,   // [2:0] event_kind
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data   // max_payload_len
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration is taken at any cycle
    assign cfg_ready = 1'b1;

    // handshakes, replay sequencing and output valid
    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // header hunt, frame store, decode and output register
    sfd_datapath #(
        .INFO_COUNT_BITS (INFO_COUNT_BITS),
        .TDATA_W         (TDATA_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_byte   (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .m_kind   (m_tuser),
        .m_data   (m_tdata)
    );

endmodule

[rtl/sfd_ctrl.sv]
// Controller of the scale frame deframer: handshakes and replay sequencing.
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_action,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    logic        accept;
    logic        feed_byte;

    assign s_tready  = (state_reg == ST_RUN) && (!ovalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign feed_byte = accept && !s_action;
    assign m_tvalid  = ovalid_reg;

    always_comb
    begin
        cmd.feed_en     = feed_byte || (state_reg == ST_REPLAY);
        cmd.sel_replay  = (state_reg == ST_REPLAY);
        cmd.rep_idx     = idx_reg;
        cmd.sess_clear  = accept && s_action;
        cmd.load_out    = feed_byte && status.ev_valid;
        cmd.capture_rep = feed_byte && status.rep_req;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            ovalid_next = 1'b1;
        end
        unique case (state_reg)
            ST_RUN:
            begin
                if (cmd.capture_rep)
                begin
                    state_next = ST_REPLAY;
                    idx_next   = status.rep_short ? 2'd3 : 2'd0;
                end
            end
            ST_REPLAY:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_no_accept_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPLAY) |-> !s_tready)
        else $error("input taken during replay");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!ovalid_reg || m_tready))
        else $error("pending result overwritten");

    a_replay_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPLAY && idx_reg == 2'd3) |=> (state_reg == ST_RUN))
        else $error("replay did not finish");

    a_replay_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPLAY) |-> !status.ev_valid)
        else $error("replayed byte finished a request");

endmodule

[rtl/sfd_datapath.sv]
// Datapath of the scale frame deframer: header hunt, frame store and decode.
module sfd_datapath
    import sfd_pkg::*;
#(
    parameter int INFO_COUNT_BITS = 16,
    parameter int TDATA_W         = 72
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         s_byte,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic [2:0]         m_kind,
    output logic [TDATA_W-1:0] m_data
);

    // the reported info count is always 16 bits wide, whatever the counter width
    localparam int INFO_OUT_W = 16;
    localparam int FIELDS_W   = 50 + INFO_OUT_W;

    phase_t                     phase_reg, phase_next;
    logic [8:0]                 cnt_reg, cnt_next;
    logic                       resp_reg, resp_next;
    logic [INFO_COUNT_BITS-1:0] info_reg, info_next;
    logic                       wseen_reg, wseen_next;
    logic [7:0]                 max_len_reg;
    logic [7:0]                 hdr_reg [0:2];
    logic [7:0]                 win_reg [0:8];
    logic [7:0]                 rep_reg [0:3];
    logic [7:0]                 win_w   [0:8];

    logic [7:0]  b;
    logic        in_frame;
    logic [8:0]  cnt_inc;
    logic [8:0]  msg_end;
    logic        hdr_we, win_we;
    logic [1:0]  hidx;
    logic [3:0]  widx;
    logic        is_check, over_len, done;

    kind_t       kind_c;
    logic [23:0] mag_c;
    logic [7:0]  dec_c;
    logic        neg_c, first_c, is_weight;
    logic [6:0]  batt_c;

    kind_t                 kind_q;
    logic [7:0]            type_q;
    logic [23:0]           mag_q;
    logic [7:0]            dec_q;
    logic                  neg_q, first_q, resp_q;
    logic [6:0]            batt_q;
    logic [INFO_OUT_W-1:0] info_q;

    assign b        = cmd.sel_replay ? rep_reg[cmd.rep_idx] : s_byte;
    assign in_frame = (phase_reg == PH_FRAME);
    assign cnt_inc  = cnt_reg + 9'd1;
    assign msg_end  = POS_BODY + {1'b0, hdr_reg[1]};
    assign hdr_we   = in_frame && (cnt_reg >= POS_HDR) && (cnt_reg <= POS_HDR_LAST);
    assign win_we   = in_frame && (cnt_reg >= POS_BODY) && (cnt_reg <= POS_BODY_END);
    assign hidx     = 2'(cnt_reg - POS_HDR);
    assign widx     = 4'(cnt_reg - POS_BODY);
    assign is_check = in_frame && (cnt_inc == POS_CHECK);
    assign over_len = hdr_reg[1] > max_len_reg;
    assign done     = in_frame && (cnt_inc >= POS_CHECK) && (cnt_inc >= msg_end);

    always_comb
    begin
        status.ev_valid  = (is_check && over_len) || done;
        status.rep_req   = (is_check && over_len) || (done && hdr_reg[1] == 8'd0);
        status.rep_short = !(is_check && over_len);
    end

    // window with the current byte written, so the last body byte decodes at once
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            win_w[i] = win_reg[i];
        end
        if (win_we)
        begin
            win_w[widx] = b;
        end
    end

    // decode of a finished frame
    always_comb
    begin
        kind_c    = KIND_OTHER;
        mag_c     = 24'd0;
        dec_c     = 8'd0;
        neg_c     = 1'b0;
        batt_c    = 7'd0;
        is_weight = 1'b0;
        if (is_check && over_len)
        begin
            kind_c = KIND_RESYNC;
        end
        else if (hdr_reg[0] == TYPE_WEIGHT && hdr_reg[2] == EVT_WEIGHT)
        begin
            if (msg_end >= END_WEIGHT)
            begin
                is_weight = 1'b1;
                mag_c     = {win_w[2], win_w[1], win_w[0]};
                dec_c     = win_w[4];
                neg_c     = win_w[5] > 8'd1;
            end
        end
        else if (hdr_reg[0] == TYPE_WEIGHT && hdr_reg[2] == EVT_BEAT)
        begin
            if (msg_end >= END_BEAT && win_w[2] == BEAT_SEL)
            begin
                is_weight = 1'b1;
                mag_c     = {win_w[5], win_w[4], win_w[3]};
                dec_c     = win_w[7];
                neg_c     = win_w[8] > 8'd1;
            end
        end
        else if (hdr_reg[0] == TYPE_BATTERY)
        begin
            batt_c = hdr_reg[2][6:0] & BATT_MASK;
            kind_c = (batt_c <= BATT_FULL) ? KIND_BATTERY : KIND_BATT_OOR;
        end
        if (is_weight)
        begin
            kind_c = KIND_WEIGHT;
        end
        first_c = is_weight && !wseen_reg;
    end

    // deframer state
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        resp_next  = resp_reg;
        info_next  = info_reg;
        wseen_next = wseen_reg;
        if (cmd.sess_clear)
        begin
            phase_next = PH_IDLE;
            cnt_next   = 9'd0;
            resp_next  = 1'b0;
            info_next  = '0;
            wseen_next = 1'b0;
        end
        else if (cmd.feed_en)
        begin
            if (!in_frame)
            begin
                if (phase_reg == PH_SAW_EF && b == SYNC_BYTE_1)
                begin
                    phase_next = PH_FRAME;
                    cnt_next   = POS_HDR;
                end
                else
                begin
                    phase_next = (b == SYNC_BYTE_0) ? PH_SAW_EF : PH_IDLE;
                end
            end
            else
            begin
                cnt_next = cnt_inc;
                if (is_check)
                begin
                    if (hdr_reg[0] != TYPE_INFO)
                    begin
                        resp_next = 1'b1;
                    end
                    else if (info_reg != '1)
                    begin
                        info_next = info_reg + INFO_COUNT_BITS'(1);
                    end
                end
                if ((is_check && over_len) || done)
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = 9'd0;
                end
                if (done && !(is_check && over_len) && is_weight)
                begin
                    wseen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= 9'd0;
            resp_reg    <= 1'b0;
            info_reg    <= '0;
            wseen_reg   <= 1'b0;
            max_len_reg <= MAX_LEN_RST;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            resp_reg  <= resp_next;
            info_reg  <= info_next;
            wseen_reg <= wseen_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.feed_en && hdr_we)
        begin
            hdr_reg[hidx] <= b;
        end
        if (cmd.feed_en && win_we)
        begin
            win_reg[widx] <= b;
        end
        if (cmd.capture_rep)
        begin
            rep_reg[0] <= hdr_reg[0];
            rep_reg[1] <= hdr_reg[1];
            rep_reg[2] <= hdr_reg[2];
            rep_reg[3] <= b;
        end
        if (cmd.load_out)
        begin
            kind_q  <= kind_c;
            type_q  <= hdr_reg[0];
            mag_q   <= mag_c;
            dec_q   <= dec_c;
            neg_q   <= neg_c;
            first_q <= first_c;
            batt_q  <= batt_c;
            resp_q  <= resp_next;
            info_q  <= INFO_OUT_W'(info_next);
        end
    end

    assign m_kind = kind_q;
    assign m_data = {{(TDATA_W - FIELDS_W){1'b0}}, info_q, resp_q, batt_q,
                     first_q, neg_q, dec_q, mag_q, type_q};

endmodule
